// ----- hdl/positional_list_store_macros.svh -----
// ---------------------------------------------------------------------------
// positional list store assertion macros
// shared concurrent assertion forms for the list store checks
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_STORE_MACROS_SVH
`define POSITIONAL_LIST_STORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define PLS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define PLS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/pls_pkg.sv -----
// ---------------------------------------------------------------------------
// pls_pkg
// types, command codes and status codes of the positional list store
// ---------------------------------------------------------------------------
package pls_pkg;

   // field widths
   localparam int CMD_W      = 3;
   localparam int POSITION_W = 7;
   localparam int VALUE_W    = 8;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 7;

   // command codes
   localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_INS_POS   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DEL_POS   = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

   // request beat
   typedef struct packed {
      logic [CMD_W-1:0]      cmd;
      logic [POSITION_W-1:0] position;
      logic [VALUE_W-1:0]    value;
   } req_type;

   // result beat
   typedef struct packed {
      logic [VALUE_W-1:0]  removed_value;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
   } rsp_type;

   // kind of list change a command makes
   typedef enum logic [1:0] {
      OP_NONE,
      OP_INS,
      OP_DEL
   } op_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic setup;
      logic rd;
      logic place;
      logic commit;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      op_type op_dec;
      op_type op_cur;
      logic   rem_zero;
   } dp_status_type;

endpackage

// ----- hdl/pls_ctrl.sv -----
// ---------------------------------------------------------------------------
// pls_ctrl
// sequencer: decide, walk the cell memory, place the new byte, reply
// ---------------------------------------------------------------------------
module pls_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  pls_pkg::dp_status_type dp_status,
   output pls_pkg::ctrl_cmd_type  ctrl_cmd
);
   import pls_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_SHIFT,
      S_PLACE,
      S_REPLY
   } state_type;

   state_type state_ff;
   logic      busy_ff;

   // state and busy flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  state_ff <= S_DECIDE;
                  busy_ff  <= 1'b1;
               end
            end
            S_DECIDE: begin
               if (dp_status.op_dec == OP_NONE) state_ff <= S_REPLY;
               else state_ff <= S_SHIFT;
            end
            S_SHIFT: begin
               if (dp_status.rem_zero) begin
                  if (dp_status.op_cur == OP_INS) state_ff <= S_PLACE;
                  else state_ff <= S_REPLY;
               end
            end
            S_PLACE: begin
               state_ff <= S_REPLY;
            end
            S_REPLY: begin
               state_ff <= S_IDLE;
               busy_ff  <= 1'b0;
            end
            default: begin
               state_ff <= S_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

   assign busy = busy_ff;

   // datapath commands per state
   always_comb begin
      ctrl_cmd        = '0;
      ctrl_cmd.load   = (state_ff == S_IDLE) && start;
      ctrl_cmd.setup  = (state_ff == S_DECIDE);
      ctrl_cmd.rd     = (state_ff == S_SHIFT) && !dp_status.rem_zero;
      ctrl_cmd.place  = (state_ff == S_PLACE);
      ctrl_cmd.commit = (state_ff == S_REPLY);
   end

endmodule

// ----- hdl/pls_datapath.sv -----
// ---------------------------------------------------------------------------
// pls_datapath
// cell memory, element count, command checks and the shifting walk
// ---------------------------------------------------------------------------
module pls_datapath #(
   parameter int CAPACITY = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pls_pkg::ctrl_cmd_type  ctrl_cmd,
   output pls_pkg::dp_status_type dp_status,
   input  pls_pkg::req_type       req_item,
   output logic                   rsp_strobe,
   output pls_pkg::rsp_type       rsp_item
);
   import pls_pkg::*;

   localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int HW    = $clog2(CAPACITY + 1);
   localparam int CMPA  = (HW + 1 > POSITION_W) ? HW + 1 : POSITION_W;
   localparam int CMPW  = (CMPA > COUNT_W) ? CMPA : COUNT_W;

   logic [VALUE_W-1:0] mem [CAPACITY];

   req_type             req_ff;
   logic [HW-1:0]       held_ff;
   logic [HW-1:0]       held_in;
   op_type              op_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [AW-1:0]       idx_ff;
   logic [HW-1:0]       rem_ff;
   logic [AW-1:0]       ptr_ff;
   logic                rd_vld_ff;
   logic [AW-1:0]       rd_addr_ff;
   logic [VALUE_W-1:0]  rd_data_ff;
   logic [VALUE_W-1:0]  removed_ff;
   logic                rsp_strobe_ff;
   rsp_type             rsp_ff;

   logic [CMPW-1:0]     pos_wide;
   logic [CMPW-1:0]     held_wide;
   logic [CMPW-1:0]     idx_wide;
   logic [CMPW-1:0]     count_wide;
   logic                full;
   logic                empty;
   op_type              op_dec;
   logic [STATUS_W-1:0] status_dec;

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [VALUE_W-1:0]  wr_data;

   // request capture
   always_ff @(posedge clock) begin
      if (ctrl_cmd.load) req_ff <= req_item;
   end

   // command checks against the current count
   always_comb begin
      pos_wide   = CMPW'(req_ff.position);
      held_wide  = CMPW'(held_ff);
      full       = (held_ff == HW'(CAPACITY));
      empty      = (held_ff == '0);
      op_dec     = OP_NONE;
      status_dec = ST_OK;
      idx_wide   = '0;
      unique case (req_ff.cmd)
         CMD_INS_FRONT: begin
            if (full) status_dec = ST_FULL;
            else op_dec = OP_INS;
         end
         CMD_INS_BACK: begin
            if (full) begin
               status_dec = ST_FULL;
            end else begin
               op_dec   = OP_INS;
               idx_wide = held_wide;
            end
         end
         CMD_INS_POS: begin
            if (full) begin
               status_dec = ST_FULL;
            end else if (pos_wide == '0 || pos_wide > held_wide + 1'b1) begin
               status_dec = ST_BADPOS;
            end else begin
               op_dec   = OP_INS;
               idx_wide = pos_wide - 1'b1;
            end
         end
         CMD_DEL_FRONT: begin
            if (empty) status_dec = ST_EMPTY;
            else op_dec = OP_DEL;
         end
         CMD_DEL_POS: begin
            if (empty) begin
               status_dec = ST_EMPTY;
            end else if (pos_wide == '0 || pos_wide > held_wide) begin
               status_dec = ST_BADPOS;
            end else begin
               op_dec   = OP_DEL;
               idx_wide = pos_wide - 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // walk control: op kind, remaining reads, read pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff     <= OP_NONE;
         rem_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= ctrl_cmd.rd;
         if (ctrl_cmd.setup) begin
            op_ff  <= op_dec;
            rem_ff <= HW'(held_wide - idx_wide);
         end else if (ctrl_cmd.rd) begin
            rem_ff <= rem_ff - 1'b1;
         end
      end
   end

   // insert walks from the tail down, delete walks from the index up
   always_ff @(posedge clock) begin
      if (ctrl_cmd.setup) begin
         status_ff <= status_dec;
         idx_ff    <= AW'(idx_wide);
         if (op_dec == OP_INS) ptr_ff <= AW'(held_wide - 1'b1);
         else ptr_ff <= AW'(idx_wide);
      end else if (ctrl_cmd.rd) begin
         if (op_ff == OP_INS) ptr_ff <= AW'(ptr_ff - 1'b1);
         else ptr_ff <= AW'(ptr_ff + 1'b1);
      end
   end

   // write port: shifted element, or the new byte at its slot
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = req_ff.value;
      priority if (rd_vld_ff && (op_ff == OP_INS || rd_addr_ff != idx_ff)) begin
         wr_en   = 1'b1;
         wr_data = rd_data_ff;
         if (op_ff == OP_INS) wr_addr = AW'(rd_addr_ff + 1'b1);
         else wr_addr = AW'(rd_addr_ff - 1'b1);
      end else if (ctrl_cmd.place) begin
         wr_en = 1'b1;
      end else begin
         wr_en = 1'b0;
      end
   end

   // cell memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (ctrl_cmd.rd) begin
         rd_data_ff <= mem[ptr_ff];
         rd_addr_ff <= ptr_ff;
      end
   end

   // first element read by a delete is the one removed
   always_ff @(posedge clock) begin
      if (rd_vld_ff && op_ff == OP_DEL && rd_addr_ff == idx_ff) removed_ff <= rd_data_ff;
   end

   // new count
   always_comb begin
      unique case (op_ff)
         OP_INS:  held_in = held_ff + 1'b1;
         OP_DEL:  held_in = held_ff - 1'b1;
         default: held_in = held_ff;
      endcase
      count_wide = CMPW'(held_in);
   end

   // count and result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= ctrl_cmd.commit;
         if (ctrl_cmd.commit) held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.commit) begin
         rsp_ff.removed_value <= (op_ff == OP_DEL) ? removed_ff : '0;
         rsp_ff.status        <= status_ff;
         rsp_ff.count         <= count_wide[COUNT_W-1:0];
      end
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_item           = rsp_ff;
   assign dp_status.op_dec   = op_dec;
   assign dp_status.op_cur   = op_ff;
   assign dp_status.rem_zero = (rem_ff == '0);

endmodule

// ----- hdl/positional_list_store.sv -----
// From accept to result strobe, an insert or delete walks count minus the 0-based
// index elements; rejected or unknown commands skip the walk.
// One command at a time; the next is taken at the edge that ends the strobe.
// The time a command takes is set by the element-by-element walk, one read and one write a cycle.
// Reset clears the count and the sequencer; the cell memory is not cleared.
// ---------------------------------------------------------------------------
// positional_list_store
// bounded ordered byte list with insert and delete at front, back or position
// ---------------------------------------------------------------------------
`include "positional_list_store_macros.svh"

module positional_list_store #(
   parameter int CAPACITY = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  pls_pkg::req_type req_item,
   output logic             rsp_strobe,
   output pls_pkg::rsp_type rsp_item
);
   import pls_pkg::*;

   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;

   // sequencer
   pls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .dp_status (dp_status),
      .ctrl_cmd  (ctrl_cmd)
   );

   // storage and checks
   pls_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctrl_cmd   (ctrl_cmd),
      .dp_status  (dp_status),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   // checks
`PLS_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "busy not raised after accept")
`PLS_ASSERT_IMPLY(a_strobe_idle, clock, reset, rsp_strobe, !busy, "result beat while still busy")
`PLS_ASSERT_IMPLY(a_empty_count, clock, reset, rsp_strobe && rsp_item.status == ST_EMPTY, rsp_item.count == '0, "empty status with nonzero count")
`PLS_ASSERT_IMPLY(a_removed_ok, clock, reset, rsp_strobe && rsp_item.removed_value != '0, rsp_item.status == ST_OK, "removed byte on a failed command")

endmodule

// ----- verif/positional_list_store_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// positional_list_store_checker
// watches the command and result channels of the list store, keeps its own
// copy of the list, predicts each result and compares it field by field
// ---------------------------------------------------------------------------
module positional_list_store_checker #(
   parameter int CAPACITY = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  pls_pkg::req_type req_item,
   input  logic             rsp_strobe,
   input  pls_pkg::rsp_type rsp_item,
   output int               fail_count,
   output int               pending
);
   import pls_pkg::*;

   // shadow copy of the list
   logic [VALUE_W-1:0] list_cells [CAPACITY];
   int                 list_len = 0;

   // results still owed by the block, oldest first
   rsp_type            owed_results [$];
   int                 mismatches = 0;

   // apply one command to the shadow list and return the result it causes
   function automatic rsp_type list_update(input req_type r);
      rsp_type res;
      int      idx;
      int      i;
      res               = '0;
      res.status        = ST_OK;
      res.removed_value = '0;
      case (r.cmd)
         CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_POS: begin
            if (list_len >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               if (r.cmd == CMD_INS_FRONT) idx = 0;
               else if (r.cmd == CMD_INS_BACK) idx = list_len;
               else idx = int'(r.position) - 1;
               if (idx < 0 || idx > list_len) begin
                  res.status = ST_BADPOS;
               end else begin
                  for (i = list_len; i > idx; i--) list_cells[i] = list_cells[i-1];
                  list_cells[idx] = r.value;
                  list_len++;
               end
            end
         end
         CMD_DEL_FRONT, CMD_DEL_POS: begin
            if (list_len == 0) begin
               res.status = ST_EMPTY;
            end else begin
               if (r.cmd == CMD_DEL_FRONT) idx = 0;
               else idx = int'(r.position) - 1;
               if (idx < 0 || idx >= list_len) begin
                  res.status = ST_BADPOS;
               end else begin
                  res.removed_value = list_cells[idx];
                  for (i = idx; i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
                  list_len--;
               end
            end
         end
         default: begin
            // unused codes leave the list alone
         end
      endcase
      res.count = COUNT_W'(list_len);
      return res;
   endfunction

   // compare results first, then record the command accepted at this edge
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         list_len = 0;
         owed_results.delete();
      end else begin
         if (rsp_strobe === 1'b1) begin
            if (owed_results.size() == 0) begin
               $error("result beat with no command waiting: removed_value %0d status %0d count %0d",
                      rsp_item.removed_value, rsp_item.status, rsp_item.count);
               mismatches++;
            end else begin
               want = owed_results.pop_front();
               if (rsp_item.removed_value !== want.removed_value) begin
                  $error("removed_value: expected %0d, actual %0d",
                         want.removed_value, rsp_item.removed_value);
                  mismatches++;
               end
               if (rsp_item.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_item.status);
                  mismatches++;
               end
               if (rsp_item.count !== want.count) begin
                  $error("count: expected %0d, actual %0d", want.count, rsp_item.count);
                  mismatches++;
               end
            end
         end
         if (start === 1'b1 && busy === 1'b0) owed_results.push_back(list_update(req_item));
      end
      fail_count <= mismatches;
      pending    <= owed_results.size();
   end

endmodule

// ----- verif/positional_list_store_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// positional_list_store_tb
// drives directed and phased random list commands into the list store, with
// random sender gaps and drain pauses; the checker predicts and compares
// ---------------------------------------------------------------------------
module positional_list_store_tb;
   import pls_pkg::*;

   localparam int CAPACITY     = 64;
   localparam int RANDOM_ITEMS = 1350;
   localparam int TAIL_ITEMS   = 150;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_LIMIT  = 2000;
   localparam int SETTLE_CYCLES = 100;

   // codes the block ignores
   localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;

   typedef enum int {
      PHASE_GROW,
      PHASE_SHRINK,
      PHASE_MIXED
   } phase_kind;

   logic    clock      = 1'b0;
   logic    reset      = 1'b1;
   logic    start      = 1'b0;
   logic    busy;
   req_type req_item   = '0;
   logic    rsp_strobe;
   rsp_type rsp_item;
   int      fail_count;
   int      pending;
   int      cycle_count;

   // length the list should have, used to aim positions and to count full and empty hits
   int      list_level = 0;
   int      cmd_tally [8];
   int      full_hits  = 0;
   int      empty_hits = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   positional_list_store #(
      .CAPACITY(CAPACITY)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   positional_list_store_checker #(
      .CAPACITY(CAPACITY)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("run stopped at the cycle limit with %0d results owed", pending);
      $display("TB_ERROR");
      $finish;
   end

   // tally each command and follow the list length for position aiming
   task automatic track_level(input logic [CMD_W-1:0] c, input logic [POSITION_W-1:0] p);
      cmd_tally[c]++;
      if (c == CMD_INS_FRONT || c == CMD_INS_BACK || c == CMD_INS_POS) begin
         if (list_level >= CAPACITY) full_hits++;
         else if (c != CMD_INS_POS || (p >= 1 && p <= list_level + 1)) list_level++;
      end else if (c == CMD_DEL_FRONT || c == CMD_DEL_POS) begin
         if (list_level == 0) empty_hits++;
         else if (c != CMD_DEL_POS || (p >= 1 && p <= list_level)) list_level--;
      end
   endtask

   // one command beat; start stays high afterwards
   task automatic issue_command(input logic [CMD_W-1:0] c, input logic [POSITION_W-1:0] p,
                                input logic [VALUE_W-1:0] v);
      start    <= 1'b1;
      req_item <= req_type'{cmd: c, position: p, value: v};
      do @(posedge clock); while (busy !== 1'b0);
      track_level(c, p);
   endtask

   task automatic rest_gap(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // hold off until every owed result has come
   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   function automatic logic [CMD_W-1:0] pick_command(input phase_kind mode);
      int roll;
      int ins_share;
      roll = $urandom_range(0, 99);
      case (mode)
         PHASE_GROW:   ins_share = 85;
         PHASE_SHRINK: ins_share = 10;
         default:      ins_share = 47;
      endcase
      if (roll >= 95) return CMD_UNUSED_FIRST + CMD_W'($urandom_range(0, 2));
      if (roll < ins_share) begin
         case ($urandom_range(0, 2))
            0:       return CMD_INS_FRONT;
            1:       return CMD_INS_BACK;
            default: return CMD_INS_POS;
         endcase
      end
      return ($urandom_range(0, 1) == 0) ? CMD_DEL_FRONT : CMD_DEL_POS;
   endfunction

   // mostly valid positions, some just outside, some anywhere in the field
   function automatic logic [POSITION_W-1:0] pick_position(input logic [CMD_W-1:0] c);
      int top_pos;
      int roll;
      top_pos = (c == CMD_DEL_POS || c == CMD_DEL_FRONT) ? list_level : list_level + 1;
      if (top_pos < 1) top_pos = 1;
      roll = $urandom_range(0, 99);
      if (roll < 75) return POSITION_W'($urandom_range(1, top_pos));
      if (roll < 82) return '0;
      if (roll < 90) return POSITION_W'(top_pos + 1);
      return POSITION_W'($urandom_range(0, 127));
   endfunction

   initial begin
      phase_kind         mode;
      int                phase_len;
      int                k;
      int                known_sent;
      int                waited;
      bit                quiet;
      logic [CMD_W-1:0]  c;
      foreach (cmd_tally[i]) cmd_tally[i] = 0;
      known_sent = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty list, bad positions at both ends, front/back/middle, unused codes
      issue_command(CMD_DEL_FRONT, 7'd0, 8'h00);
      issue_command(CMD_DEL_POS, 7'd0, 8'h00);
      issue_command(CMD_DEL_POS, 7'd1, 8'hFF);
      issue_command(CMD_INS_POS, 7'd0, 8'h11);
      issue_command(CMD_INS_POS, 7'd2, 8'h22);
      issue_command(CMD_INS_POS, 7'd1, 8'hA5);
      issue_command(CMD_INS_FRONT, 7'd0, 8'hFF);
      rest_gap(3);
      issue_command(CMD_INS_BACK, 7'd127, 8'h00);
      issue_command(CMD_INS_POS, 7'd4, 8'h5A);
      issue_command(CMD_INS_POS, 7'd2, 8'h01);
      issue_command(CMD_INS_POS, 7'd7, 8'h33);
      issue_command(CMD_INS_POS, 7'd127, 8'h80);
      issue_command(CMD_DEL_POS, 7'd0, 8'h00);
      issue_command(CMD_DEL_POS, 7'd6, 8'h00);
      issue_command(CMD_DEL_POS, 7'd127, 8'h00);
      issue_command(CMD_DEL_POS, 7'd5, 8'h00);
      issue_command(CMD_DEL_POS, 7'd1, 8'h00);
      issue_command(CMD_DEL_FRONT, 7'd64, 8'h00);
      issue_command(CMD_UNUSED_FIRST, 7'd3, 8'hFF);
      issue_command(CMD_UNUSED_FIRST + 3'd1, 7'd0, 8'h00);
      issue_command(CMD_UNUSED_FIRST + 3'd2, 7'd127, 8'h7F);
      issue_command(CMD_DEL_POS, 7'd2, 8'h00);
      issue_command(CMD_DEL_FRONT, 7'd0, 8'h00);
      issue_command(CMD_INS_BACK, 7'd0, 8'h3C);
      drain_results();

      // random phases that fill, empty or churn the list
      while (known_sent < RANDOM_ITEMS) begin
         mode      = phase_kind'($urandom_range(0, 2));
         phase_len = $urandom_range(16, 160);
         quiet     = ($urandom_range(0, 3) == 0);
         for (k = 0; k < phase_len && known_sent < RANDOM_ITEMS; k++) begin
            c = pick_command(mode);
            issue_command(c, pick_position(c), VALUE_W'($urandom_range(0, 255)));
            if (c <= CMD_DEL_POS) known_sent++;
            if (!quiet && known_sent < RANDOM_ITEMS - TAIL_ITEMS &&
                $urandom_range(0, 2) == 0)
               rest_gap($urandom_range(1, 6));
         end
         if (known_sent < RANDOM_ITEMS - TAIL_ITEMS && $urandom_range(0, 4) == 0)
            drain_results();
      end

      // wait for the last results, then let the block settle
      start  <= 1'b0;
      waited = 0;
      do begin
         @(posedge clock);
         waited++;
      end while (pending != 0 && waited < DRAIN_LIMIT);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("commands: ins front %0d, ins back %0d, ins pos %0d, del front %0d, del pos %0d",
               cmd_tally[CMD_INS_FRONT], cmd_tally[CMD_INS_BACK], cmd_tally[CMD_INS_POS],
               cmd_tally[CMD_DEL_FRONT], cmd_tally[CMD_DEL_POS]);
      $display("ignored codes %0d, inserts on a full list %0d, deletes on an empty list %0d",
               cmd_tally[5] + cmd_tally[6] + cmd_tally[7], full_hits, empty_hits);
      if (fail_count == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("failures %0d, results still owed %0d", fail_count, pending);
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
